@@ rtl/core/rcs_pkg.sv @@
// ----------------------------------------------------------------------------
// rcs_pkg
// Shared types and constants of the count sketch core.
// ----------------------------------------------------------------------------
package rcs_pkg;

    localparam int CNT_W   = 32;   // counter width
    localparam int SUM_W   = 35;   // row sum width
    localparam int EST_W   = 40;   // Q.8 estimate width
    localparam int QW      = SUM_W + 8; // dividend width of the Q.8 mean
    localparam int HASHES  = 8;    // hash fields carried by one word
    localparam int IN_W    = 296;  // input tdata width
    localparam int OUT_W   = 112;  // output tdata width
    localparam int MODE_W  = 3;

    localparam logic [MODE_W-1:0] MODE_ADD      = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SUB      = 3'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_COMPRESS = 3'd3;
    localparam logic [MODE_W-1:0] MODE_EXPAND   = 3'd4;
    localparam logic [MODE_W-1:0] MODE_MAX      = 3'd5;
    localparam logic [MODE_W-1:0] MODE_CLEAR    = 3'd6;
    localparam logic [MODE_W-1:0] MODE_RSVD     = 3'd7;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_RD,
        ST_PT,
        ST_SCAN,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        WS_INC,
        WS_DEC,
        WS_SUB_ACC,
        WS_ADD_DIFF,
        WS_ZERO
    } t_wsel;

    typedef enum logic [1:0] {
        ACC_MIN,
        ACC_SUM,
        ACC_MAX
    } t_acc_op;

    typedef struct packed {
        logic    wr_en;
        t_wsel   wsel;
        logic    acc_clr;
        logic    acc_en;
        t_acc_op acc_op;
    } t_lane_ctl;

endpackage

@@ rtl/core/rcs_ram.sv @@
// ----------------------------------------------------------------------------
// rcs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rcs_ram #(
    parameter int W = 32,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/rcs_lane.sv @@
// ----------------------------------------------------------------------------
// rcs_lane
// One sketch row: counter memory, row accumulator and write-back update.
// ----------------------------------------------------------------------------
module rcs_lane #(
    parameter int RANGE = 256
) (
    input  logic                       i_clk,
    input  rcs_pkg::t_lane_ctl         i_ctl,
    input  logic [$clog2(RANGE)-1:0]   i_raddr,
    input  logic [$clog2(RANGE)-1:0]   i_waddr,
    input  logic [rcs_pkg::CNT_W-1:0]  i_total,
    output logic [rcs_pkg::CNT_W-1:0]  o_rdata,
    output logic [rcs_pkg::CNT_W-1:0]  o_acc
);

    logic [rcs_pkg::CNT_W-1:0] w_rdata;
    logic [rcs_pkg::CNT_W-1:0] w_wdata;
    logic [rcs_pkg::CNT_W-1:0] r_acc;

    rcs_ram #(.W(rcs_pkg::CNT_W), .D(RANGE)) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_ctl.wr_en),
        .i_waddr (i_waddr),
        .i_wdata (w_wdata),
        .i_raddr (i_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        case (i_ctl.wsel)
            rcs_pkg::WS_INC:      w_wdata = w_rdata + 32'd1;
            rcs_pkg::WS_DEC:      w_wdata = w_rdata - 32'd1;
            rcs_pkg::WS_SUB_ACC:  w_wdata = w_rdata - r_acc;
            // add back the wrapped difference of total and row sum
            rcs_pkg::WS_ADD_DIFF: w_wdata = w_rdata + (i_total - r_acc);
            default:              w_wdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc_clr) begin
            r_acc <= (i_ctl.acc_op == rcs_pkg::ACC_MIN) ? '1 : '0;
        end else if (i_ctl.acc_en) begin
            case (i_ctl.acc_op)
                rcs_pkg::ACC_MIN: if (w_rdata < r_acc) r_acc <= w_rdata;
                rcs_pkg::ACC_SUM: r_acc <= r_acc + w_rdata;
                rcs_pkg::ACC_MAX: if (w_rdata > r_acc) r_acc <= w_rdata;
                default:          r_acc <= r_acc;
            endcase
        end
    end

    assign o_rdata = w_rdata;
    assign o_acc   = r_acc;

endmodule

@@ rtl/core/rcs_merge.sv @@
// ----------------------------------------------------------------------------
// rcs_merge
// Combine lanes: sum of the read counters and largest lane maximum.
// ----------------------------------------------------------------------------
module rcs_merge #(
    parameter int ROWS = 8
) (
    input  logic [rcs_pkg::CNT_W-1:0] i_data [ROWS],
    input  logic [rcs_pkg::CNT_W-1:0] i_acc  [ROWS],
    output logic [rcs_pkg::SUM_W-1:0] o_sum,
    output logic [rcs_pkg::CNT_W-1:0] o_max
);

    always_comb begin
        o_sum = '0;
        o_max = '0;
        for (int l = 0; l < ROWS; l++) begin
            o_sum = o_sum + rcs_pkg::SUM_W'(i_data[l]);
            if (i_acc[l] > o_max) o_max = i_acc[l];
        end
    end

endmodule

@@ rtl/core/race_count_sketch_core.sv @@
// ----------------------------------------------------------------------------
// race_count_sketch_core
// Count sketch of ROWS rows by RANGE counters, one memory per row lane.
//
//  channel  dir  fields (lowest bit up)
//  s_axis   in   mode[2:0] hash_0..hash_7 (32 each) total_count[31:0]
//  m_axis   out  row_sum[34:0] estimate_q8[39:0] largest_counter[31:0]
//
// Add and subtract update the addressed counters; query sums them into a Q.8 mean
// by ROWS, one quotient byte per cycle. Compress and expand read, then write back,
// max counter reads, clear writes: each is a sweep through the row memories, all
// lanes at once. After reset a clearing pass runs before the first word. A finished
// word waits in the output register; the next one is accepted.
// ----------------------------------------------------------------------------
module race_count_sketch_core #(
    parameter int ROWS  = 8,
    parameter int RANGE = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // mode[2:0], hash_0[34:3] .. hash_7[258:227], total_count[290:259], zero fill
    input  logic [rcs_pkg::IN_W-1:0]   i_s_axis_tdata,
    output logic                       o_m_axis_tvalid,
    input  logic                       i_m_axis_tready,
    // row_sum[34:0], estimate_q8[74:35], largest_counter[106:75], zero fill
    output logic [rcs_pkg::OUT_W-1:0]  o_m_axis_tdata
);

    localparam int IW = $clog2(RANGE);
    localparam int RW = $clog2(ROWS) + 1;
    localparam logic [IW-1:0] LAST = IW'(RANGE - 1);
    localparam int TOT_LO = rcs_pkg::MODE_W + rcs_pkg::HASHES * rcs_pkg::CNT_W;
    localparam int DG  = 8;                            // quotient bits per cycle
    localparam int ND  = (rcs_pkg::QW + DG - 1) / DG;  // quotient digits
    localparam int DVW = ND * DG;
    localparam int XW  = RW + DG;
    localparam int SH  = XW + RW;
    localparam logic [SH:0] RECIP =
        (SH + 1)'(((64'd1 << SH) + 64'(ROWS) - 64'd1) / 64'(ROWS));

    rcs_pkg::t_state r_state, n_state;
    rcs_pkg::t_lane_ctl w_ctl;

    logic                          r_item;
    logic [rcs_pkg::MODE_W-1:0]    r_mode;
    logic [IW-1:0]                 r_idx [ROWS];
    logic [rcs_pkg::CNT_W-1:0]     r_total;
    logic [IW-1:0]                 r_addr;
    logic [IW-1:0]                 r_daddr;
    logic                          r_issue;
    logic                          r_dv;
    logic                          r_pass;
    logic [rcs_pkg::SUM_W-1:0]     r_sum;
    logic [DVW-1:0]                r_dvd;
    logic [DVW-1:0]                r_quo;
    logic [RW-1:0]                 r_rem;
    logic [5:0]                    r_dcnt;
    logic                          r_ovalid;
    logic [rcs_pkg::OUT_W-1:0]     r_odata;

    logic [IW-1:0]                 w_raddr [ROWS];
    logic [IW-1:0]                 w_waddr [ROWS];
    logic [rcs_pkg::CNT_W-1:0]     w_rdata [ROWS];
    logic [rcs_pkg::CNT_W-1:0]     w_acc   [ROWS];
    logic [rcs_pkg::SUM_W-1:0]     w_sum;
    logic [rcs_pkg::CNT_W-1:0]     w_max;
    logic                          w_in_acc;
    logic                          w_ld;
    logic                          w_scan_end;
    logic [XW-1:0]                 w_x;
    logic [XW+SH:0]                w_prod;
    logic [DG-1:0]                 w_qd;
    logic [XW-1:0]                 w_qm;
    logic [XW-1:0]                 w_rm;
    logic [rcs_pkg::MODE_W-1:0]    w_in_mode;

    assign w_in_mode  = i_s_axis_tdata[rcs_pkg::MODE_W-1:0];
    assign o_s_axis_tready = (r_state == rcs_pkg::ST_IDLE);
    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_ld       = (r_state == rcs_pkg::ST_OUT) && (!r_ovalid || i_m_axis_tready);
    assign w_scan_end = r_dv && (r_daddr == LAST);

    // long division by ROWS, one byte of quotient per cycle by reciprocal multiply
    assign w_x    = {r_rem, r_dvd[DVW-1 -: DG]};
    assign w_prod = (XW + SH + 1)'(w_x) * (XW + SH + 1)'(RECIP);
    assign w_qd   = w_prod[SH +: DG];
    assign w_qm   = XW'(w_qd) * XW'(ROWS);
    assign w_rm   = w_x - w_qm;

    // lanes
    for (genvar l = 0; l < ROWS; l++) begin : g_lane
        always_comb begin
            case (r_state)
                rcs_pkg::ST_RD, rcs_pkg::ST_PT: begin
                    w_raddr[l] = r_idx[l];
                    w_waddr[l] = r_idx[l];
                end
                rcs_pkg::ST_SCAN: begin
                    w_raddr[l] = r_addr;
                    w_waddr[l] = r_daddr;
                end
                default: begin
                    w_raddr[l] = r_addr;
                    w_waddr[l] = r_addr;
                end
            endcase
        end

        rcs_lane #(.RANGE(RANGE)) u_lane (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_raddr (w_raddr[l]),
            .i_waddr (w_waddr[l]),
            .i_total (r_total),
            .o_rdata (w_rdata[l]),
            .o_acc   (w_acc[l])
        );
    end

    rcs_merge #(.ROWS(ROWS)) u_merge (
        .i_data (w_rdata),
        .i_acc  (w_acc),
        .o_sum  (w_sum),
        .o_max  (w_max)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rcs_pkg::ST_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        w_ctl.wr_en   = 1'b0;
        w_ctl.wsel    = rcs_pkg::WS_ZERO;
        w_ctl.acc_clr = 1'b0;
        w_ctl.acc_en  = 1'b0;
        case (r_mode)
            rcs_pkg::MODE_COMPRESS: w_ctl.acc_op = rcs_pkg::ACC_MIN;
            rcs_pkg::MODE_EXPAND:   w_ctl.acc_op = rcs_pkg::ACC_SUM;
            default:                w_ctl.acc_op = rcs_pkg::ACC_MAX;
        endcase
        case (r_state)
            rcs_pkg::ST_CLR: begin
                w_ctl.wr_en = 1'b1;
                if (r_addr == LAST) n_state = r_item ? rcs_pkg::ST_OUT : rcs_pkg::ST_IDLE;
            end
            rcs_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    case (w_in_mode)
                        rcs_pkg::MODE_ADD, rcs_pkg::MODE_SUB,
                        rcs_pkg::MODE_QUERY:    n_state = rcs_pkg::ST_RD;
                        rcs_pkg::MODE_COMPRESS, rcs_pkg::MODE_EXPAND,
                        rcs_pkg::MODE_MAX:      n_state = rcs_pkg::ST_SCAN;
                        rcs_pkg::MODE_CLEAR:    n_state = rcs_pkg::ST_CLR;
                        default:                n_state = rcs_pkg::ST_OUT;
                    endcase
                end
            end
            rcs_pkg::ST_RD: n_state = rcs_pkg::ST_PT;
            rcs_pkg::ST_PT: begin
                w_ctl.wr_en = (r_mode == rcs_pkg::MODE_ADD) || (r_mode == rcs_pkg::MODE_SUB);
                w_ctl.wsel  = (r_mode == rcs_pkg::MODE_ADD) ? rcs_pkg::WS_INC : rcs_pkg::WS_DEC;
                n_state = (r_mode == rcs_pkg::MODE_QUERY) ? rcs_pkg::ST_DIV : rcs_pkg::ST_OUT;
            end
            rcs_pkg::ST_SCAN: begin
                // first read of the first pass: data arrives next cycle
                w_ctl.acc_clr = !r_pass && r_issue && (r_addr == '0);
                w_ctl.acc_en  = r_dv && !r_pass;
                w_ctl.wr_en   = r_dv && r_pass;
                w_ctl.wsel    = (r_mode == rcs_pkg::MODE_COMPRESS) ? rcs_pkg::WS_SUB_ACC
                                                                   : rcs_pkg::WS_ADD_DIFF;
                if (w_scan_end && (r_pass || r_mode == rcs_pkg::MODE_MAX)) begin
                    n_state = rcs_pkg::ST_OUT;
                end
            end
            rcs_pkg::ST_DIV: begin
                if (r_dcnt == 6'(ND - 1)) n_state = rcs_pkg::ST_OUT;
            end
            rcs_pkg::ST_OUT: begin
                if (w_ld) n_state = rcs_pkg::ST_IDLE;
            end
            default: n_state = rcs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item   <= 1'b0;
            r_addr   <= '0;
            r_issue  <= 1'b0;
            r_dv     <= 1'b0;
            r_pass   <= 1'b0;
            r_dcnt   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_dv    <= (r_state == rcs_pkg::ST_SCAN) && r_issue;
            r_daddr <= r_addr;
            if (i_m_axis_tready && !w_ld) r_ovalid <= 1'b0;
            case (r_state)
                rcs_pkg::ST_CLR: r_addr <= r_addr + 1'b1;
                rcs_pkg::ST_IDLE: begin
                    if (w_in_acc) begin
                        r_item  <= 1'b1;
                        r_mode  <= w_in_mode;
                        for (int l = 0; l < ROWS; l++) begin
                            r_idx[l] <= i_s_axis_tdata[rcs_pkg::MODE_W + l*rcs_pkg::CNT_W +: IW];
                        end
                        r_total <= i_s_axis_tdata[TOT_LO +: rcs_pkg::CNT_W];
                        r_sum   <= '0;
                        r_quo   <= '0;
                        r_addr  <= '0;
                        r_pass  <= 1'b0;
                        r_dcnt  <= '0;
                        r_issue <= (w_in_mode == rcs_pkg::MODE_COMPRESS) ||
                                   (w_in_mode == rcs_pkg::MODE_EXPAND) ||
                                   (w_in_mode == rcs_pkg::MODE_MAX);
                    end
                end
                rcs_pkg::ST_PT: begin
                    if (r_mode == rcs_pkg::MODE_QUERY) begin
                        r_sum <= w_sum;
                        r_dvd <= DVW'({w_sum, 8'd0});
                        r_rem <= '0;
                    end
                end
                rcs_pkg::ST_SCAN: begin
                    if (r_issue) begin
                        r_addr <= r_addr + 1'b1;
                        if (r_addr == LAST) r_issue <= 1'b0;
                    end
                    // start the write-back pass; r_addr has wrapped to zero
                    if (w_scan_end && !r_pass && r_mode != rcs_pkg::MODE_MAX) begin
                        r_pass  <= 1'b1;
                        r_issue <= 1'b1;
                    end
                end
                rcs_pkg::ST_DIV: begin
                    r_dcnt <= r_dcnt + 6'd1;
                    r_dvd  <= {r_dvd[DVW-DG-1:0], {DG{1'b0}}};
                    r_rem  <= w_rm[RW-1:0];
                    r_quo  <= {r_quo[DVW-DG-1:0], w_qd};
                end
                rcs_pkg::ST_OUT: begin
                    if (w_ld) begin
                        r_ovalid <= 1'b1;
                        r_item   <= 1'b0;
                        r_odata  <= {5'd0,
                                     (r_mode == rcs_pkg::MODE_MAX) ? w_max : 32'd0,
                                     r_quo[rcs_pkg::EST_W-1:0], r_sum};
                    end
                end
                default: r_addr <= r_addr;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

`ifndef ASSERT_OFF
    a_dv_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv |-> (r_state == rcs_pkg::ST_SCAN))
        else $error("read data valid outside a sweep");
    a_div_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rcs_pkg::ST_DIV) |-> (r_dcnt < 6'(ND)))
        else $error("divider ran past its last digit");
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> ($past(r_state) == rcs_pkg::ST_OUT))
        else $error("result word appeared without a finished item");
`endif

endmodule
